FILE: design/mtp_pkg.sv
`default_nettype none
package mtp_pkg;

	localparam int MAX_RES  = 6;
	localparam int FIFO_AW  = 4;
	localparam int FIFO_DEP = 1 << FIFO_AW;
	localparam int ADDR_W   = 3;

	// register index within the configuration map
	localparam logic [ADDR_W-3:0] REG_MT32 = 1'b0;

	localparam logic [2:0] K_BYTE  = 3'd0;
	localparam logic [2:0] K_DELTA = 3'd1;
	localparam logic [2:0] K_TEMPO = 3'd2;
	localparam logic [2:0] K_END   = 3'd3;
	localparam logic [2:0] K_STRAY = 3'd4;

	localparam logic [7:0] META_END   = 8'h2F;
	localparam logic [7:0] META_TEMPO = 8'h51;
	localparam logic [7:0] ST_SYSEX   = 8'hF0;
	localparam logic [7:0] ST_ESCAPE  = 8'hF7;
	localparam logic [7:0] ST_META    = 8'hFF;
	localparam logic [7:0] ST_TUNE    = 8'hF6;
	localparam logic [7:0] ST_MTC     = 8'hF1;
	localparam logic [7:0] ST_SPP     = 8'hF2;
	localparam logic [7:0] ST_SONG    = 8'hF3;
	localparam logic [7:0] CC_VALUE   = 8'd127;

	typedef enum logic [3:0] {
		PH_DELTA,
		PH_EVENT,
		PH_CHAN,
		PH_SX_LEN,
		PH_SX_DATA,
		PH_META_TYPE,
		PH_META_LEN,
		PH_META_DATA,
		PH_SKIP,
		PH_ENDED
	} phase_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [31:0] value;
		logic        last;
	} result_t;

	typedef struct packed {
		logic                  wr;
		logic [2:0]            n;
		result_t [MAX_RES-1:0] item;
	} res_bundle_t;

endpackage
`default_nettype wire

FILE: design/mtp_cfg.sv
`default_nettype none
module mtp_cfg import mtp_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [31:0]       pwdata,
	output logic      [31:0]       prdata,
	output logic                   pready,
	output logic                   mt32_mode
);

	logic mt32_q;
	logic wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && (paddr[ADDR_W-1:2] == REG_MT32);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mt32_q <= 1'b0;
		end else if (wr_en) begin
			mt32_q <= pwdata[0];
		end
	end

	always_comb begin
		prdata = 32'd0;
		if (paddr[ADDR_W-1:2] == REG_MT32) begin
			prdata = {31'd0, mt32_q};
		end
	end

	assign mt32_mode = mt32_q;

endmodule
`default_nettype wire

FILE: design/mtp_parser.sv
`default_nettype none
module mtp_parser import mtp_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  byte_valid,
	output logic       byte_stall,
	input  wire logic  [7:0] data_byte,
	input  wire logic  track_start,
	input  wire logic  mt32_mode,
	input  wire logic  room,
	output res_bundle_t bundle
);

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        start_s1;
	logic        fire;
	logic        take;

	phase_t      phase_q, phase_d;
	logic [31:0] acc_q, acc_d;
	logic [7:0]  rs_q, rs_d;
	logic [1:0]  dc_q, dc_d;
	logic [7:0]  sent_q, sent_d;
	logic [7:0]  ms_q, ms_d;
	logic [7:0]  md0_q, md0_d;
	logic [7:0]  md1_q, md1_d;
	logic [1:0]  di_q, di_d;
	logic [7:0]  meta_q, meta_d;
	logic [31:0] rem_q, rem_d;
	logic [23:0] tempo_q, tempo_d;

	result_t [MAX_RES-1:0] res;
	logic [2:0]  n;

	assign fire       = valid_s1 && room;
	assign byte_stall = valid_s1 && !room;
	assign take       = byte_valid && !byte_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			byte_s1  <= data_byte;
			start_s1 <= track_start;
		end
	end

	always_comb begin
		logic [7:0]  b;
		logic [7:0]  s;
		logic [3:0]  ch;
		logic [1:0]  cnt;
		logic        fin;
		logic [31:0] acc_sh;
		b        = byte_s1;
		s        = '0;
		ch       = '0;
		cnt      = '0;
		fin      = 1'b0;
		n        = 3'd0;
		res      = '0;
		phase_d  = phase_q;
		acc_d    = acc_q;
		rs_d     = rs_q;
		dc_d     = dc_q;
		sent_d   = sent_q;
		ms_d     = ms_q;
		md0_d    = md0_q;
		md1_d    = md1_q;
		di_d     = di_q;
		meta_d   = meta_q;
		rem_d    = rem_q;
		tempo_d  = tempo_q;

		if (start_s1) begin
			phase_d = PH_DELTA;
			acc_d   = '0;
			rs_d    = '0;
			dc_d    = '0;
			ms_d    = '0;
			md0_d   = '0;
			md1_d   = '0;
			di_d    = '0;
			meta_d  = '0;
			rem_d   = '0;
			tempo_d = '0;
		end

		acc_sh = {acc_d[24:0], b[6:0]};

		unique case (phase_d)
			PH_EVENT: begin
				phase_d = PH_DELTA;
				if (!b[7]) begin
					if (rs_d == 8'd0) begin
						res[n].kind  = K_STRAY;
						res[n].value = {24'd0, b};
						n = n + 3'd1;
					end else begin
						ms_d  = rs_d;
						md0_d = b;
						di_d  = 2'd1;
						if (dc_d <= 2'd1) begin
							fin = 1'b1;
						end else begin
							phase_d = PH_CHAN;
						end
					end
				end else if (b[7:4] != 4'hF) begin
					rs_d    = b;
					dc_d    = (b[7:4] == 4'hC || b[7:4] == 4'hD) ? 2'd1 : 2'd2;
					ms_d    = b;
					di_d    = 2'd0;
					phase_d = PH_CHAN;
				end else if (b[3] && b != ST_META) begin
					// real-time bytes pass straight through
					res[n].kind  = K_BYTE;
					res[n].value = {24'd0, b};
					n = n + 3'd1;
				end else begin
					sent_d = 8'd0;
					acc_d  = '0;
					case (b)
						ST_SYSEX: begin
							res[n].kind  = K_BYTE;
							res[n].value = {24'd0, ST_SYSEX};
							n = n + 3'd1;
							phase_d = PH_SX_LEN;
						end
						ST_ESCAPE: phase_d = PH_SX_LEN;
						ST_META:   phase_d = PH_META_TYPE;
						ST_MTC, ST_SONG: begin
							rem_d   = 32'd1;
							phase_d = PH_SKIP;
						end
						ST_SPP: begin
							rem_d   = 32'd2;
							phase_d = PH_SKIP;
						end
						ST_TUNE: begin
							res[n].kind  = K_BYTE;
							res[n].value = {24'd0, ST_TUNE};
							n = n + 3'd1;
						end
						default: ;
					endcase
				end
			end
			PH_CHAN: begin
				if (di_d[0]) begin
					md1_d = b;
				end else begin
					md0_d = b;
				end
				di_d = di_d + 2'd1;
				if (di_d >= dc_d || di_d >= 2'd2) begin
					fin = 1'b1;
				end
			end
			PH_SX_LEN: begin
				acc_d = acc_sh;
				if (!b[7]) begin
					rem_d   = acc_sh;
					acc_d   = '0;
					phase_d = (acc_sh != 32'd0) ? PH_SX_DATA : PH_DELTA;
				end
			end
			PH_SX_DATA: begin
				res[n].kind  = K_BYTE;
				res[n].value = {24'd0, b};
				n = n + 3'd1;
				rem_d = rem_d - 32'd1;
				if (rem_d == 32'd0) begin
					phase_d = PH_DELTA;
				end
			end
			PH_META_TYPE: begin
				meta_d  = b;
				acc_d   = '0;
				phase_d = PH_META_LEN;
			end
			PH_META_LEN: begin
				acc_d = acc_sh;
				if (!b[7]) begin
					rem_d   = acc_sh;
					acc_d   = '0;
					tempo_d = '0;
					di_d    = '0;
					if (meta_d == META_END) begin
						res[n].kind  = K_END;
						res[n].value = 32'd0;
						n = n + 3'd1;
						phase_d = PH_ENDED;
					end else if (acc_sh == 32'd0) begin
						if (meta_d == META_TEMPO) begin
							res[n].kind  = K_TEMPO;
							res[n].value = 32'd0;
							n = n + 3'd1;
						end
						phase_d = PH_DELTA;
					end else begin
						phase_d = PH_META_DATA;
					end
				end
			end
			PH_META_DATA: begin
				if (meta_d == META_TEMPO && di_d != 2'd3) begin
					case (di_d)
						2'd0:    tempo_d[23:16] = tempo_d[23:16] | b;
						2'd1:    tempo_d[15:8]  = tempo_d[15:8] | b;
						default: tempo_d[7:0]   = tempo_d[7:0] | b;
					endcase
					di_d = di_d + 2'd1;
				end
				rem_d = rem_d - 32'd1;
				if (rem_d == 32'd0) begin
					if (meta_d == META_TEMPO) begin
						res[n].kind  = K_TEMPO;
						res[n].value = {8'd0, tempo_d};
						n = n + 3'd1;
					end
					di_d    = '0;
					phase_d = PH_DELTA;
				end
			end
			PH_SKIP: begin
				if (rem_d != 32'd0) begin
					rem_d = rem_d - 32'd1;
				end
				if (rem_d == 32'd0) begin
					phase_d = PH_DELTA;
				end
			end
			PH_ENDED: ;
			default: begin
				acc_d = acc_sh;
				if (!b[7]) begin
					res[n].kind  = K_DELTA;
					res[n].value = acc_sh;
					n = n + 3'd1;
					acc_d   = '0;
					phase_d = PH_EVENT;
				end else begin
					phase_d = PH_DELTA;
				end
			end
		endcase

		// close channel msg: expand, MT-32 CC, note-off fix, recompress status
		if (fin) begin
			s   = ms_d;
			ch  = ms_d[3:0];
			cnt = (dc_d > 2'd2) ? 2'd2 : dc_d;
			if (mt32_mode && s[7:4] == 4'hC) begin
				res[n].kind  = K_BYTE;
				res[n].value = {24'd0, 4'hB, ch};
				n = n + 3'd1;
				res[n].kind  = K_BYTE;
				res[n].value = 32'd0;
				n = n + 3'd1;
				res[n].kind  = K_BYTE;
				res[n].value = {24'd0, CC_VALUE};
				n = n + 3'd1;
				sent_d = {4'hB, ch};
			end
			if (s[7:4] == 4'h8) begin
				s     = {4'h9, ch};
				md1_d = 8'd0;
			end
			if (sent_d != s) begin
				res[n].kind  = K_BYTE;
				res[n].value = {24'd0, s};
				n = n + 3'd1;
			end
			if (cnt >= 2'd1) begin
				res[n].kind  = K_BYTE;
				res[n].value = {24'd0, md0_d};
				n = n + 3'd1;
			end
			if (cnt >= 2'd2) begin
				res[n].kind  = K_BYTE;
				res[n].value = {24'd0, md1_d};
				n = n + 3'd1;
			end
			sent_d  = s;
			di_d    = 2'd0;
			phase_d = PH_DELTA;
		end

		for (int i = 0; i < MAX_RES; i++) begin
			res[i].last = (n != 3'd0) && (i == 32'(n) - 1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_DELTA;
			acc_q   <= '0;
			rs_q    <= '0;
			dc_q    <= '0;
			sent_q  <= '0;
			ms_q    <= '0;
			md0_q   <= '0;
			md1_q   <= '0;
			di_q    <= '0;
			meta_q  <= '0;
			rem_q   <= '0;
			tempo_q <= '0;
		end else if (fire) begin
			phase_q <= phase_d;
			acc_q   <= acc_d;
			rs_q    <= rs_d;
			dc_q    <= dc_d;
			sent_q  <= sent_d;
			ms_q    <= ms_d;
			md0_q   <= md0_d;
			md1_q   <= md1_d;
			di_q    <= di_d;
			meta_q  <= meta_d;
			rem_q   <= rem_d;
			tempo_q <= tempo_d;
		end
	end

	always_comb begin
		bundle.wr   = fire;
		bundle.n    = n;
		bundle.item = res;
	end

endmodule
`default_nettype wire

FILE: design/mtp_result_fifo.sv
`default_nettype none
module mtp_result_fifo import mtp_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire res_bundle_t bundle,
	output logic             room,
	output logic             result_valid,
	input  wire logic        result_stall,
	output logic [2:0]       kind,
	output logic [31:0]      value,
	output logic             last
);

	result_t              mem_q [FIFO_DEP];
	logic [FIFO_AW-1:0]   wp_q;
	logic [FIFO_AW-1:0]   rp_q;
	logic [FIFO_AW:0]     cnt_q;
	logic                 pop;
	logic [FIFO_AW:0]     add;

	// keep space for the largest burst one item can cause
	assign room         = cnt_q <= (FIFO_AW+1)'(FIFO_DEP - MAX_RES);
	assign result_valid = cnt_q != '0;
	assign pop          = result_valid && !result_stall;
	assign add          = bundle.wr ? (FIFO_AW+1)'(bundle.n) : '0;

	always_ff @(posedge clk) begin
		for (int i = 0; i < MAX_RES; i++) begin
			if (bundle.wr && i < 32'(bundle.n)) begin
				mem_q[wp_q + FIFO_AW'(i)] <= bundle.item[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			wp_q  <= wp_q + add[FIFO_AW-1:0];
			if (pop) begin
				rp_q <= rp_q + 1'b1;
			end
			cnt_q <= cnt_q + add - (FIFO_AW+1)'(pop);
		end
	end

	assign kind  = mem_q[rp_q].kind;
	assign value = mem_q[rp_q].value;
	assign last  = mem_q[rp_q].last;

endmodule
`default_nettype wire

FILE: design/midi_track_event_parser_unit.sv
`default_nettype none
// Parses the bytes of one MIDI track, one byte per item, into a stream of results: delta
// times, tempo changes, end of track, stray data flags and the re-encoded MIDI output bytes
// (running status expanded, note-off rewritten as note-on with velocity 0, status
// recompressed, optional controller 0 = 127 ahead of each program change). A byte is taken
// every cycle unless stalled; it is registered, then parsed into a 16-entry result queue
// that drains one result per cycle unless stalled. One byte can cause up to five results,
// so byte_stall rises while the queue holds more than ten; with results drained freely the
// sustained rate is one byte per cycle whenever bytes average at most one result each.
// mt32_mode sits at byte address 0; the user must write it only while idle (not enforced).
module midi_track_event_parser_unit import mtp_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [31:0]       pwdata,
	output logic      [31:0]       prdata,
	output logic                   pready,
	input  wire logic              byte_valid,
	output logic                   byte_stall,
	input  wire logic [7:0]        data_byte,
	input  wire logic              track_start,
	output logic                   result_valid,
	input  wire logic              result_stall,
	output logic      [2:0]        kind,
	output logic      [31:0]       value,
	output logic                   last
);

	logic        mt32_mode;
	logic        room;
	res_bundle_t bundle;

	mtp_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.mt32_mode (mt32_mode)
	);

	mtp_parser u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.byte_valid  (byte_valid),
		.byte_stall  (byte_stall),
		.data_byte   (data_byte),
		.track_start (track_start),
		.mt32_mode   (mt32_mode),
		.room        (room),
		.bundle      (bundle)
	);

	mtp_result_fifo u_fifo (
		.clk          (clk),
		.arst_n       (arst_n),
		.bundle       (bundle),
		.room         (room),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.kind         (kind),
		.value        (value),
		.last         (last)
	);

endmodule
`default_nettype wire

FILE: test/midi_track_event_parser_unit_tb.sv
`timescale 1ns / 1ps
module midi_track_event_parser_unit_tb import mtp_pkg::*;;

	localparam int HOLD_CYCLES   = 300;
	localparam int QUIET_LIMIT   = 5000;
	localparam int SETTLE_CYCLES = 20;
	localparam int OPENING_LEN   = 27;

	localparam logic [3:0] NIB_NOTE_OFF   = 4'h8;
	localparam logic [3:0] NIB_NOTE_ON    = 4'h9;
	localparam logic [3:0] NIB_CTRL       = 4'hB;
	localparam logic [3:0] NIB_PROG       = 4'hC;
	localparam logic [3:0] NIB_CHAN_PRESS = 4'hD;
	localparam logic [7:0] RT_FIRST       = 8'hF8;
	localparam logic [7:0] RT_LAST        = 8'hFE;
	localparam logic [7:0] UNDEF_F4       = 8'hF4;
	localparam logic [7:0] UNDEF_F5       = 8'hF5;

	// stray byte, over-long delta, note-off, running status, program change, tempo, end
	localparam logic [OPENING_LEN*8-1:0] OPENING = {
		8'h00, 8'h45, 8'h8F, 8'hFF, 8'hFF, 8'hFF, 8'h7F,
		{NIB_NOTE_OFF, 4'h0}, 8'h3C, 8'h40,
		8'h00, 8'h7F, 8'h7F,
		8'h00, {NIB_PROG, 4'hF}, 8'h05,
		8'h00, ST_META, META_TEMPO, 8'h03, 8'h07, 8'hA1, 8'h20,
		8'h00, ST_META, META_END, 8'h00
	};

	typedef struct packed {
		logic [7:0] data;
		logic       start;
	} track_byte_t;

	logic              clk;
	logic              arst_n       = 1'b0;
	logic              psel         = 1'b0;
	logic              penable      = 1'b0;
	logic              pwrite       = 1'b0;
	logic [ADDR_W-1:0] paddr        = '0;
	logic [31:0]       pwdata       = '0;
	logic [31:0]       prdata;
	logic              pready;
	logic              byte_valid   = 1'b0;
	logic              byte_stall;
	logic [7:0]        data_byte    = '0;
	logic              track_start  = 1'b0;
	logic              result_valid;
	logic              result_stall = 1'b0;
	logic [2:0]        kind;
	logic [31:0]       value;
	logic              last;

	midi_track_event_parser_unit dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
		.prdata(prdata), .pready(pready),
		.byte_valid(byte_valid), .byte_stall(byte_stall),
		.data_byte(data_byte), .track_start(track_start),
		.result_valid(result_valid), .result_stall(result_stall),
		.kind(kind), .value(value), .last(last)
	);

	// parser state as the block should hold it
	phase_t      ph;
	logic [31:0] acc;
	logic [7:0]  run_status;
	logic [1:0]  run_count;
	logic [7:0]  sent_status;
	logic [7:0]  msg_status;
	logic [7:0]  msg_data [2];
	logic [1:0]  data_idx;
	logic [7:0]  meta_kind;
	logic [31:0] remaining;
	logic [23:0] tempo_acc;
	logic        mt32_on;

	result_t       step_out [$];
	result_t       parsed_results [$];
	track_byte_t   track_bytes [$];
	track_byte_t   next_byte;
	result_t       want;

	int unsigned queued = 0;
	logic        new_track = 1'b0;
	logic        has_status = 1'b0;
	int unsigned status_len = 0;

	int          fail_count = 0;
	int          quiet_cycles = 0;
	logic        byte_took = 1'b0;
	logic        result_took = 1'b0;
	int          tx_gap = 0;
	logic [5:0]  tx_tick = '0;
	logic        tx_steady = 1'b0;
	int          rx_gap = 0;
	logic [5:0]  rx_tick = '0;
	logic        rx_steady = 1'b0;
	int          hold_left = 0;
	logic        hold_req = 1'b0;
	logic        hold_seen = 1'b0;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic void post(input logic [2:0] k, input logic [31:0] v);
		result_t r;
		r.kind  = k;
		r.value = v;
		r.last  = 1'b0;
		step_out.push_back(r);
	endfunction

	function automatic void clear_track();
		ph          = PH_DELTA;
		acc         = '0;
		run_status  = '0;
		run_count   = '0;
		msg_status  = '0;
		msg_data[0] = '0;
		msg_data[1] = '0;
		data_idx    = '0;
		meta_kind   = '0;
		remaining   = '0;
		tempo_acc   = '0;
	endfunction

	function automatic logic take_varlen(input logic [7:0] b);
		acc = {acc[24:0], b[6:0]};
		return !b[7];
	endfunction

	function automatic void send_channel();
		logic [7:0] s;
		logic [1:0] n;
		s = msg_status;
		n = (run_count > 2'd2) ? 2'd2 : run_count;
		if (mt32_on && s[7:4] == NIB_PROG) begin
			post(K_BYTE, {24'h0, NIB_CTRL, s[3:0]});
			post(K_BYTE, 32'h0);
			post(K_BYTE, {24'h0, CC_VALUE});
			sent_status = {NIB_CTRL, s[3:0]};
		end
		if (s[7:4] == NIB_NOTE_OFF) begin
			s = {NIB_NOTE_ON, s[3:0]};
			msg_data[1] = '0;
		end
		if (sent_status != s)
			post(K_BYTE, {24'h0, s});
		for (int i = 0; i < n; i++)
			post(K_BYTE, {24'h0, msg_data[i]});
		sent_status = s;
		data_idx = '0;
		ph = PH_DELTA;
	endfunction

	function automatic void start_event(input logic [7:0] b);
		ph = PH_DELTA;
		if (!b[7]) begin
			if (run_status == 8'h0) begin
				post(K_STRAY, {24'h0, b});
			end else begin
				msg_status  = run_status;
				msg_data[0] = b;
				data_idx    = 2'd1;
				if (run_count <= 2'd1)
					send_channel();
				else
					ph = PH_CHAN;
			end
		end else if (b < ST_SYSEX) begin
			run_status = b;
			run_count  = (b[7:4] == NIB_PROG || b[7:4] == NIB_CHAN_PRESS) ? 2'd1 : 2'd2;
			msg_status = b;
			data_idx   = '0;
			ph         = PH_CHAN;
		end else if (b >= RT_FIRST && b <= RT_LAST) begin
			post(K_BYTE, {24'h0, b});
		end else begin
			sent_status = '0;
			acc = '0;
			case (b)
				ST_SYSEX: begin
					post(K_BYTE, {24'h0, ST_SYSEX});
					ph = PH_SX_LEN;
				end
				ST_ESCAPE: ph = PH_SX_LEN;
				ST_META: ph = PH_META_TYPE;
				ST_MTC, ST_SONG: begin
					remaining = 32'd1;
					ph = PH_SKIP;
				end
				ST_SPP: begin
					remaining = 32'd2;
					ph = PH_SKIP;
				end
				ST_TUNE: post(K_BYTE, {24'h0, ST_TUNE});
				default: ;
			endcase
		end
	endfunction

	function automatic void parse_track_byte(input logic [7:0] b, input logic start);
		step_out.delete();
		if (start)
			clear_track();
		case (ph)
			PH_EVENT: start_event(b);
			PH_CHAN: begin
				msg_data[data_idx[0]] = b;
				data_idx++;
				if (data_idx >= run_count || data_idx >= 2'd2)
					send_channel();
			end
			PH_SX_LEN: begin
				if (take_varlen(b)) begin
					remaining = acc;
					acc = '0;
					ph = (remaining != 0) ? PH_SX_DATA : PH_DELTA;
				end
			end
			PH_SX_DATA: begin
				post(K_BYTE, {24'h0, b});
				remaining--;
				if (remaining == 0)
					ph = PH_DELTA;
			end
			PH_META_TYPE: begin
				meta_kind = b;
				acc = '0;
				ph = PH_META_LEN;
			end
			PH_META_LEN: begin
				if (take_varlen(b)) begin
					remaining = acc;
					acc = '0;
					tempo_acc = '0;
					data_idx = '0;
					if (meta_kind == META_END) begin
						post(K_END, 32'h0);
						ph = PH_ENDED;
					end else if (remaining == 0) begin
						if (meta_kind == META_TEMPO)
							post(K_TEMPO, 32'h0);
						ph = PH_DELTA;
					end else begin
						ph = PH_META_DATA;
					end
				end
			end
			PH_META_DATA: begin
				if (meta_kind == META_TEMPO && data_idx < 2'd3) begin
					case (data_idx)
						2'd0: tempo_acc[23:16] |= b;
						2'd1: tempo_acc[15:8] |= b;
						default: tempo_acc[7:0] |= b;
					endcase
					data_idx++;
				end
				remaining--;
				if (remaining == 0) begin
					if (meta_kind == META_TEMPO)
						post(K_TEMPO, {8'h0, tempo_acc});
					data_idx = '0;
					ph = PH_DELTA;
				end
			end
			PH_SKIP: begin
				if (remaining > 0)
					remaining--;
				if (remaining == 0)
					ph = PH_DELTA;
			end
			PH_ENDED: ;
			default: begin
				if (take_varlen(b)) begin
					post(K_DELTA, acc);
					acc = '0;
					ph = PH_EVENT;
				end else begin
					ph = PH_DELTA;
				end
			end
		endcase
		if (step_out.size() != 0)
			step_out[step_out.size() - 1].last = 1'b1;
		foreach (step_out[i])
			parsed_results.push_back(step_out[i]);
	endfunction

	function automatic int pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// track byte generation
	function automatic void put(input logic [7:0] b);
		track_byte_t t;
		t.data  = b;
		t.start = new_track;
		new_track = 1'b0;
		track_bytes.push_back(t);
		queued++;
	endfunction

	function automatic logic [7:0] rand7();
		return 8'($urandom_range(0, 127));
	endfunction

	function automatic logic [7:0] rand8();
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic void put_varlen(input logic [31:0] v);
		logic [6:0] grp [5];
		logic [31:0] rest;
		int n;
		rest = v;
		n = 0;
		do begin
			grp[n] = rest[6:0];
			rest = rest >> 7;
			n++;
		end while (rest != 0);
		for (int i = n - 1; i >= 0; i--)
			put({i != 0, grp[i]});
	endfunction

	function automatic void put_delta();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 75) begin
			put_varlen($urandom_range(0, 127));
		end else if (r < 90) begin
			put_varlen($urandom_range(128, 16383));
		end else if (r < 97) begin
			put_varlen($urandom & 32'h0FFF_FFFF);
		end else begin
			// five groups: keep only the low 32 bits
			put(8'h80 | rand8());
			repeat (3) put(8'h80 | rand8());
			put(rand7());
		end
	endfunction

	function automatic void gen_event();
		int unsigned pick, len;
		logic [3:0] nib;
		logic [7:0] mtype;
		pick = $urandom_range(0, 99);
		if (pick < 38) begin
			nib = NIB_NOTE_OFF + 4'($urandom_range(0, 6));
			put({nib, 4'($urandom_range(0, 15))});
			status_len = (nib == NIB_PROG || nib == NIB_CHAN_PRESS) ? 1 : 2;
			has_status = 1'b1;
			repeat (status_len) put(rand7());
		end else if (pick < 58) begin
			// running status, or a stray byte when none is stored
			if (has_status)
				repeat (status_len) put(rand7());
			else
				put(rand7());
		end else if (pick < 66) begin
			put(pick < 62 ? ST_SYSEX : ST_ESCAPE);
			len = $urandom_range(0, 5);
			put_varlen(len);
			repeat (len) put(rand8());
		end else if (pick < 72) begin
			put(ST_META);
			put(META_TEMPO);
			len = $urandom_range(0, 1) ? 3 : $urandom_range(0, 5);
			put_varlen(len);
			repeat (len) put(rand8());
		end else if (pick < 78) begin
			put(ST_META);
			do
				mtype = rand8();
			while (mtype == META_END || mtype == META_TEMPO);
			put(mtype);
			len = $urandom_range(0, 3);
			if ($urandom_range(0, 3) == 0)
				put(8'h80);
			put(8'(len));
			repeat (len) put(rand8());
		end else if (pick < 84) begin
			case ($urandom_range(0, 5))
				0: begin
					put(ST_MTC);
					put(rand7());
				end
				1: begin
					put(ST_SONG);
					put(rand7());
				end
				2: begin
					put(ST_SPP);
					put(rand7());
					put(rand7());
				end
				3: put(ST_TUNE);
				4: put(UNDEF_F4);
				default: put(UNDEF_F5);
			endcase
		end else if (pick < 92) begin
			put(8'($urandom_range(RT_FIRST, RT_LAST)));
		end else if (pick < 96) begin
			put(rand7());
		end else begin
			put(rand8());
		end
	endfunction

	function automatic void gen_track(input int unsigned budget);
		int unsigned stop_at;
		new_track = 1'b1;
		has_status = 1'b0;
		stop_at = queued + budget;
		while (queued < stop_at) begin
			put_delta();
			gen_event();
		end
		if ($urandom_range(0, 1)) begin
			put_delta();
			put(ST_META);
			put(META_END);
			if ($urandom_range(0, 3) == 0) begin
				put(8'h02);
				put(rand8());
				put(rand8());
			end else begin
				put(8'h00);
			end
			repeat ($urandom_range(0, 2)) put(rand8());
		end
	endfunction

	function automatic void gen_tracks(input int unsigned count);
		int unsigned stop_at;
		stop_at = queued + count;
		while (queued < stop_at)
			gen_track($urandom_range(4, 40));
	endfunction

	task automatic set_mt32(input logic on);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {REG_MT32, 2'b00};
		pwdata  <= {31'h0, on};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		mt32_on = on;
		// read it back
		@(negedge clk);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== {31'h0, on}) begin
			$error("mt32_mode readback: expected 0x%0h, got 0x%0h", {31'h0, on}, prdata);
			fail_count++;
		end
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic drain();
		while (track_bytes.size() != 0 || byte_valid || parsed_results.size() != 0)
			@(posedge clk);
		// bytes that give no result may still be in flight
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	always @(negedge clk) begin
		if (tx_tick == 0)
			tx_steady = ($urandom_range(0, 3) == 0);
		tx_tick++;
		if (byte_valid && !byte_took) begin
			// hold the offered item
		end else if (tx_gap > 0) begin
			tx_gap--;
			byte_valid <= 1'b0;
		end else if (track_bytes.size() != 0) begin
			next_byte = track_bytes.pop_front();
			data_byte   <= next_byte.data;
			track_start <= next_byte.start;
			byte_valid  <= 1'b1;
			tx_gap = tx_steady ? 0 : pick_gap();
		end else begin
			byte_valid <= 1'b0;
		end
	end

	always @(negedge clk) begin
		if (hold_req != hold_seen) begin
			hold_seen = hold_req;
			hold_left = HOLD_CYCLES;
		end
		if (rx_tick == 0)
			rx_steady = ($urandom_range(0, 3) == 0);
		rx_tick++;
		if (hold_left > 0) begin
			hold_left--;
			result_stall <= 1'b1;
		end else if (rx_gap > 0) begin
			rx_gap--;
			result_stall <= 1'b1;
		end else begin
			result_stall <= 1'b0;
			if (!rx_steady)
				rx_gap = pick_gap();
		end
	end

	always @(posedge clk) begin
		byte_took   = arst_n && byte_valid && !byte_stall;
		result_took = arst_n && result_valid && !result_stall;
		if (result_took) begin
			if (parsed_results.size() == 0) begin
				$error("result with none awaited: kind %0d value 0x%0h last %0d",
					kind, value, last);
				fail_count++;
			end else begin
				want = parsed_results.pop_front();
				if (kind !== want.kind) begin
					$error("kind: expected %0d, got %0d", want.kind, kind);
					fail_count++;
				end
				if (value !== want.value) begin
					$error("value: expected 0x%0h, got 0x%0h", want.value, value);
					fail_count++;
				end
				if (last !== want.last) begin
					$error("last: expected %0d, got %0d", want.last, last);
					fail_count++;
				end
			end
		end
		if (byte_took)
			parse_track_byte(data_byte, track_start);
		if (!arst_n || byte_took || result_took) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("midi_track_event_parser_unit regression: fail");
				$finish;
			end
		end
	end

	initial begin
		mt32_on = 1'b0;
		sent_status = '0;
		clear_track();
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		set_mt32(1'b1);
		new_track = 1'b1;
		for (int i = OPENING_LEN - 1; i >= 0; i--)
			put(OPENING[i*8 +: 8]);
		drain();

		set_mt32(1'b0);
		gen_tracks(140);
		drain();

		// back-pressure: stop draining results while bytes keep coming
		set_mt32(1'b1);
		hold_req = ~hold_req;
		gen_tracks(140);
		drain();

		set_mt32(1'b0);
		gen_tracks(140);
		drain();

		if (fail_count == 0)
			$display("midi_track_event_parser_unit regression: pass");
		else
			$display("midi_track_event_parser_unit regression: fail");
		$finish;
	end

endmodule
